>>> sv/hmi_pkg.sv
// hmi_pkg: types, codes and constants of the hashed multi-value index
// used by hmi_store and hashed_multivalue_index_top; depends on nothing
`default_nettype none
package hmi_pkg;

  localparam int HASH_W = 32;
  localparam int CHAR_W = 21;
  localparam int MAXV_W = 6;
  localparam int COUNT_W = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_W = 4;
  localparam int IN_DATA_W = 128;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 112;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;
  localparam logic [HASH_W-1:0] MARK_EMPTY = 32'h00000000;
  localparam logic [HASH_W-1:0] MARK_TOMB = 32'hffffffff;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
  localparam logic [CFG_W:0] LOG2_MIN = 5'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7ff;

  typedef enum logic [1:0] {
    CMD_FOLD = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL = 2'd2,
    STAT_RESERVED = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FOLD,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_SLOT,
    ST_LK_START,
    ST_LK_RD,
    ST_LK_CHK,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_RH_RD,
    ST_RH_CHK,
    ST_RH_PUT_RD,
    ST_RH_PUT_WAIT,
    ST_RH_PROBE_RD,
    ST_RH_PROBE_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic slot_we;
    logic scr_we;
  } mem_wr_t;

  function automatic logic is_live(input logic [HASH_W-1:0] h);
    return (h != MARK_EMPTY) && (h != MARK_TOMB);
  endfunction

endpackage
`default_nettype wire

>>> sv/hmi_store.sv
// hmi_store: slot memory and rehash scratch memory, one write and one
// registered read port each; depends on hmi_pkg
`default_nettype none
module hmi_store #(
  parameter int AW = 10,
  parameter int VB = 64
) (
  input  wire                         clk,
  input  hmi_pkg::mem_wr_t            wr,
  input  wire  [AW-1:0]               slot_waddr,
  input  wire  [hmi_pkg::HASH_W-1:0]  slot_whash,
  input  wire  [VB-1:0]               slot_wvalue,
  input  wire  [AW-1:0]               slot_raddr,
  output logic [hmi_pkg::HASH_W-1:0]  slot_rhash,
  output logic [VB-1:0]               slot_rvalue,
  input  wire  [AW-1:0]               scr_waddr,
  input  wire  [hmi_pkg::HASH_W-1:0]  scr_whash,
  input  wire  [VB-1:0]               scr_wvalue,
  input  wire  [AW-1:0]               scr_raddr,
  output logic [hmi_pkg::HASH_W-1:0]  scr_rhash,
  output logic [VB-1:0]               scr_rvalue
);
  import hmi_pkg::*;

  localparam int DEPTH = 1 << AW;
  localparam int EW = HASH_W + VB;

  logic [EW-1:0] slot_mem [DEPTH];
  logic [EW-1:0] scr_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.slot_we) begin
      slot_mem[slot_waddr] <= {slot_whash, slot_wvalue};
    end
    {slot_rhash, slot_rvalue} <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.scr_we) begin
      scr_mem[scr_waddr] <= {scr_whash, scr_wvalue};
    end
    {scr_rhash, scr_rvalue} <= scr_mem[scr_raddr];
  end

endmodule
`default_nettype wire

>>> sv/hashed_multivalue_index_top.sv
// hashed_multivalue_index_top: fnv-1a keyed multi-value hash table with linear
// probing and in-place rehash; depends on hmi_pkg and hmi_store
// delete scans the slots in order for a live entry with the given value; an insert past
// three quarters load rehashes once and rechecks, and a delete that leaves more than
// half the slots as tombstones rehashes before it answers
// one transaction at a time, with an idle state between them, plus any output stalls
// reset (or a config write) clears the table with s_axis_tready low
`default_nettype none
module hashed_multivalue_index_top #(
  parameter int SLOTS = 1024,
  parameter int VALUE_BITS = 64
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [hmi_pkg::CFG_W-1:0]        cfg_data,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // key_char, given_hash, entry_value, max_values
  input  wire  [hmi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command, use_given_hash
  input  wire  [hmi_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // found_value, match_count, key_hash
  output logic [hmi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [hmi_pkg::STATUS_W-1:0]     m_axis_tuser,
  output logic                             m_axis_tlast
);
  import hmi_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;
  localparam int LW = AW + 4;
  localparam int VB = VALUE_BITS;
  localparam logic [CFG_W:0] LOG2_MAX = (CFG_W + 1)'(AW);

  state_t state, state_next;
  logic [CFG_W-1:0] cfg_log2, cfg_log2_next;
  logic [AW-1:0] clr, clr_next;
  logic [HASH_W-1:0] running_hash, running_hash_next;
  logic [CW-1:0] live, live_next, tomb, tomb_next;
  logic [CW-1:0] cnt, cnt_next, kcnt, kcnt_next, jcnt, jcnt_next, mcount, mcount_next;
  logic [AW-1:0] idx, idx_next;
  logic rehashed, rehashed_next, ret_ins, ret_ins_next;
  logic out_valid, out_valid_next;

  // transaction payload and result holding registers
  logic [CHAR_W-1:0] op_char, op_char_next;
  logic [HASH_W-1:0] op_hash, op_hash_next;
  logic [VB-1:0] op_value, op_value_next;
  logic [MAXV_W-1:0] op_maxv, op_maxv_next;
  status_t res_status, res_status_next;
  logic [COUNT_W-1:0] res_count, res_count_next;
  logic [HASH_W-1:0] res_hash, res_hash_next;
  status_t out_status, out_status_next;
  logic [VB-1:0] out_value, out_value_next;
  logic [COUNT_W-1:0] out_count, out_count_next;
  logic [HASH_W-1:0] out_hash, out_hash_next;
  logic out_last, out_last_next;

  mem_wr_t wr;
  logic [AW-1:0] slot_waddr, slot_raddr, scr_waddr, scr_raddr;
  logic [HASH_W-1:0] slot_whash, slot_rhash, scr_whash, scr_rhash;
  logic [VB-1:0] slot_wvalue, slot_rvalue, scr_wvalue, scr_rvalue;

  logic [CFG_W:0] lg;
  logic [CW-1:0] cap;
  logic [AW-1:0] mask, home;
  logic out_free, load_fail, tomb_fail;
  logic [HASH_W-1:0] rh_new;
  logic [COUNT_W-1:0] mcount_sat;

  hmi_store #(.AW(AW), .VB(VB)) u_store (
    .clk(clk), .wr(wr),
    .slot_waddr(slot_waddr), .slot_whash(slot_whash), .slot_wvalue(slot_wvalue),
    .slot_raddr(slot_raddr), .slot_rhash(slot_rhash), .slot_rvalue(slot_rvalue),
    .scr_waddr(scr_waddr), .scr_whash(scr_whash), .scr_wvalue(scr_wvalue),
    .scr_raddr(scr_raddr), .scr_rhash(scr_rhash), .scr_rvalue(scr_rvalue)
  );

  always_comb begin
    if ({1'b0, cfg_log2} < LOG2_MIN) begin
      lg = LOG2_MIN;
    end else if ({1'b0, cfg_log2} > LOG2_MAX) begin
      lg = LOG2_MAX;
    end else begin
      lg = {1'b0, cfg_log2};
    end
  end

  assign cap = CW'(1) << lg;
  assign mask = AW'(cap - CW'(1));
  assign home = op_hash[AW-1:0] & mask;
  assign out_free = !out_valid || m_axis_tready;
  assign load_fail = ((LW'(live) + LW'(tomb) + LW'(1)) << 2) > (LW'(cap) * LW'(3));
  assign tomb_fail = ((LW'(tomb) + LW'(1)) << 1) > LW'(cap);
  assign rh_new = 32'((running_hash ^ HASH_W'(op_char)) * FNV_PRIME);
  assign mcount_sat = ((CW + COUNT_W)'(mcount) > (CW + COUNT_W)'(COUNT_MAX)) ?
                      COUNT_MAX : COUNT_W'(mcount);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {(OUT_DATA_W - 64 - COUNT_W - HASH_W)'(0), out_hash, out_count,
                         64'(out_value)};
  assign m_axis_tuser = out_status;
  assign m_axis_tlast = out_last;

  always_comb begin
    state_next = state;
    cfg_log2_next = cfg_log2;
    clr_next = clr;
    running_hash_next = running_hash;
    live_next = live;
    tomb_next = tomb;
    cnt_next = cnt;
    kcnt_next = kcnt;
    jcnt_next = jcnt;
    mcount_next = mcount;
    idx_next = idx;
    rehashed_next = rehashed;
    ret_ins_next = ret_ins;
    out_valid_next = out_valid && !m_axis_tready;
    op_char_next = op_char;
    op_hash_next = op_hash;
    op_value_next = op_value;
    op_maxv_next = op_maxv;
    res_status_next = res_status;
    res_count_next = res_count;
    res_hash_next = res_hash;
    out_status_next = out_status;
    out_value_next = out_value;
    out_count_next = out_count;
    out_hash_next = out_hash;
    out_last_next = out_last;
    wr = '0;
    slot_waddr = idx;
    slot_whash = op_hash;
    slot_wvalue = op_value;
    slot_raddr = idx;
    scr_waddr = kcnt[AW-1:0];
    scr_whash = slot_rhash;
    scr_wvalue = slot_rvalue;
    scr_raddr = jcnt[AW-1:0];

    unique case (state)
      ST_CLEAR: begin
        wr.slot_we = 1'b1;
        slot_waddr = clr;
        slot_whash = MARK_EMPTY;
        clr_next = clr + AW'(1);
        if (&clr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_char_next = s_axis_tdata[20:0];
          op_hash_next = s_axis_tuser[2] ? s_axis_tdata[52:21] : running_hash;
          op_value_next = s_axis_tdata[53 +: VB];
          op_maxv_next = s_axis_tdata[122:117];
          rehashed_next = 1'b0;
          cnt_next = '0;
          mcount_next = '0;
          if (!s_axis_tuser[2] && (cmd_t'(s_axis_tuser[1:0]) == CMD_INSERT ||
              cmd_t'(s_axis_tuser[1:0]) == CMD_LOOKUP)) begin
            running_hash_next = FNV_BASIS;
          end
          unique case (cmd_t'(s_axis_tuser[1:0]))
            CMD_FOLD:   state_next = ST_FOLD;
            CMD_INSERT: state_next = ST_INS_CHK;
            CMD_LOOKUP: state_next = ST_LK_START;
            CMD_DELETE: state_next = ST_DEL_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_FOLD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_status_next = STAT_OK;
          out_value_next = '0;
          out_count_next = '0;
          out_hash_next = rh_new;
          out_last_next = 1'b1;
          running_hash_next = rh_new;
          state_next = ST_IDLE;
        end
      end
      ST_INS_CHK: begin
        res_hash_next = op_hash;
        res_count_next = '0;
        if (!is_live(op_hash)) begin
          res_status_next = STAT_RESERVED;
          state_next = ST_EMIT;
        end else if (load_fail) begin
          if (rehashed) begin
            res_status_next = STAT_FULL;
            state_next = ST_EMIT;
          end else begin
            ret_ins_next = 1'b1;
            cnt_next = '0;
            kcnt_next = '0;
            state_next = ST_RH_RD;
          end
        end else begin
          idx_next = home;
          state_next = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        state_next = ST_INS_SLOT;
      end
      ST_INS_SLOT: begin
        if (is_live(slot_rhash)) begin
          idx_next = (idx + AW'(1)) & mask;
          state_next = ST_INS_RD;
        end else begin
          wr.slot_we = 1'b1;
          if (slot_rhash == MARK_TOMB && tomb != '0) begin
            tomb_next = tomb - CW'(1);
          end
          live_next = live + CW'(1);
          res_status_next = STAT_OK;
          state_next = ST_EMIT;
        end
      end
      ST_LK_START: begin
        res_hash_next = op_hash;
        if (!is_live(op_hash)) begin
          res_status_next = STAT_NOT_FOUND;
          res_count_next = '0;
          state_next = ST_EMIT;
        end else begin
          idx_next = home;
          state_next = ST_LK_RD;
        end
      end
      ST_LK_RD: begin
        if (cnt == cap) begin
          res_status_next = (mcount == '0) ? STAT_NOT_FOUND : STAT_OK;
          res_count_next = mcount_sat;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_LK_CHK;
        end
      end
      ST_LK_CHK: begin
        if (slot_rhash == MARK_EMPTY) begin
          res_status_next = (mcount == '0) ? STAT_NOT_FOUND : STAT_OK;
          res_count_next = mcount_sat;
          state_next = ST_EMIT;
        end else if (slot_rhash == op_hash &&
                     (CW + MAXV_W)'(mcount) < (CW + MAXV_W)'(op_maxv)) begin
          // emitted value items wait here on a busy output register
          if (out_free) begin
            out_valid_next = 1'b1;
            out_status_next = STAT_OK;
            out_value_next = slot_rvalue;
            out_count_next = '0;
            out_hash_next = op_hash;
            out_last_next = 1'b0;
            mcount_next = mcount + CW'(1);
            idx_next = (idx + AW'(1)) & mask;
            cnt_next = cnt + CW'(1);
            state_next = ST_LK_RD;
          end
        end else begin
          if (slot_rhash == op_hash) begin
            mcount_next = mcount + CW'(1);
          end
          idx_next = (idx + AW'(1)) & mask;
          cnt_next = cnt + CW'(1);
          state_next = ST_LK_RD;
        end
      end
      ST_DEL_RD: begin
        slot_raddr = cnt[AW-1:0];
        res_count_next = '0;
        if (cnt == cap) begin
          res_status_next = STAT_NOT_FOUND;
          res_hash_next = '0;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DEL_CHK;
        end
      end
      ST_DEL_CHK: begin
        slot_raddr = cnt[AW-1:0];
        if (is_live(slot_rhash) && slot_rvalue == op_value) begin
          wr.slot_we = 1'b1;
          slot_waddr = cnt[AW-1:0];
          slot_whash = MARK_TOMB;
          if (live != '0) begin
            live_next = live - CW'(1);
          end
          tomb_next = tomb + CW'(1);
          res_status_next = STAT_OK;
          res_hash_next = slot_rhash;
          if (tomb_fail) begin
            ret_ins_next = 1'b0;
            cnt_next = '0;
            kcnt_next = '0;
            state_next = ST_RH_RD;
          end else begin
            state_next = ST_EMIT;
          end
        end else begin
          cnt_next = cnt + CW'(1);
          state_next = ST_DEL_RD;
        end
      end
      ST_RH_RD: begin
        slot_raddr = cnt[AW-1:0];
        if (cnt == cap) begin
          jcnt_next = '0;
          state_next = ST_RH_PUT_RD;
        end else begin
          state_next = ST_RH_CHK;
        end
      end
      ST_RH_CHK: begin
        // compact live entries into scratch and empty the slot behind the scan
        slot_raddr = cnt[AW-1:0];
        if (is_live(slot_rhash)) begin
          wr.scr_we = 1'b1;
          kcnt_next = kcnt + CW'(1);
        end
        wr.slot_we = 1'b1;
        slot_waddr = cnt[AW-1:0];
        slot_whash = MARK_EMPTY;
        cnt_next = cnt + CW'(1);
        state_next = ST_RH_RD;
      end
      ST_RH_PUT_RD: begin
        if (jcnt == kcnt) begin
          live_next = kcnt;
          tomb_next = '0;
          if (ret_ins) begin
            rehashed_next = 1'b1;
            state_next = ST_INS_CHK;
          end else begin
            state_next = ST_EMIT;
          end
        end else begin
          state_next = ST_RH_PUT_WAIT;
        end
      end
      ST_RH_PUT_WAIT: begin
        idx_next = scr_rhash[AW-1:0] & mask;
        state_next = ST_RH_PROBE_RD;
      end
      ST_RH_PROBE_RD: begin
        state_next = ST_RH_PROBE_CHK;
      end
      ST_RH_PROBE_CHK: begin
        if (slot_rhash != MARK_EMPTY) begin
          idx_next = (idx + AW'(1)) & mask;
          state_next = ST_RH_PROBE_RD;
        end else begin
          wr.slot_we = 1'b1;
          slot_whash = scr_rhash;
          slot_wvalue = scr_rvalue;
          jcnt_next = jcnt + CW'(1);
          state_next = ST_RH_PUT_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_status_next = res_status;
          out_value_next = '0;
          out_count_next = res_count;
          out_hash_next = res_hash;
          out_last_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      cfg_log2_next = cfg_data;
      clr_next = '0;
      live_next = '0;
      tomb_next = '0;
      state_next = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cfg_log2 <= CFG_RESET;
      clr <= '0;
      running_hash <= FNV_BASIS;
      live <= '0;
      tomb <= '0;
      cnt <= '0;
      kcnt <= '0;
      jcnt <= '0;
      mcount <= '0;
      idx <= '0;
      rehashed <= 1'b0;
      ret_ins <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cfg_log2 <= cfg_log2_next;
      clr <= clr_next;
      running_hash <= running_hash_next;
      live <= live_next;
      tomb <= tomb_next;
      cnt <= cnt_next;
      kcnt <= kcnt_next;
      jcnt <= jcnt_next;
      mcount <= mcount_next;
      idx <= idx_next;
      rehashed <= rehashed_next;
      ret_ins <= ret_ins_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_char <= op_char_next;
    op_hash <= op_hash_next;
    op_value <= op_value_next;
    op_maxv <= op_maxv_next;
    res_status <= res_status_next;
    res_count <= res_count_next;
    res_hash <= res_hash_next;
    out_status <= out_status_next;
    out_value <= out_value_next;
    out_count <= out_count_next;
    out_hash <= out_hash_next;
    out_last <= out_last_next;
  end

endmodule
`default_nettype wire
